// ===== sv/wialu_pkg.sv =====
// Shared constants and stage-to-stage types of the integer ALU.
package wialu_pkg;

  localparam int unsigned XlenW  = 64;
  localparam int unsigned HalfW  = 32;
  localparam int unsigned DivSteps = XlenW;

  // Operation codes
  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_MUL  = 4'd2;
  localparam logic [3:0] OP_DIV  = 4'd3;
  localparam logic [3:0] OP_REM  = 4'd4;
  localparam logic [3:0] OP_AND  = 4'd5;
  localparam logic [3:0] OP_OR   = 4'd6;
  localparam logic [3:0] OP_XOR  = 4'd7;
  localparam logic [3:0] OP_SHL  = 4'd8;
  localparam logic [3:0] OP_SHR  = 4'd9;
  localparam logic [3:0] OP_ROTL = 4'd10;
  localparam logic [3:0] OP_ROTR = 4'd11;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [1:0] ST_DIV_OVF  = 2'd2;

  // Control and early result carried alongside the divider
  typedef struct packed {
    logic [3:0]       mode;
    logic             wide;
    logic [1:0]       status;
    logic             neg_q;
    logic             neg_r;
    logic [XlenW-1:0] res;
  } ctl_t;

  // Restoring divider state
  typedef struct packed {
    logic [XlenW-1:0] rem;
    logic [XlenW-1:0] quo;
    logic [XlenW-1:0] dvs;
  } div_t;

endpackage

// ===== sv/wialu_if.sv =====
// Valid/ready channel interfaces for ALU requests and responses.
interface wialu_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic        is_64bit;
  logic        is_signed;
  logic [63:0] lhs_operand;
  logic [63:0] rhs_operand;
  modport source (output valid, mode, is_64bit, is_signed, lhs_operand, rhs_operand,
                  input ready);
  modport sink (input valid, mode, is_64bit, is_signed, lhs_operand, rhs_operand,
                output ready);
endinterface

interface wialu_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_value;
  logic [1:0]  status;
  modport source (output valid, result_value, status, input ready);
  modport sink (input valid, result_value, status, output ready);
endinterface

// ===== sv/wialu_front.sv =====
// Front stages: operand decode, simple ops, multiply, divider operand setup.
module wialu_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [3:0]                mode,
  input  logic                      is_64bit,
  input  logic                      is_signed,
  input  logic [63:0]               lhs_operand,
  input  logic [63:0]               rhs_operand,
  output logic                      valid,
  output wialu_pkg::ctl_t           ctl,
  output wialu_pkg::div_t           div
);
  import wialu_pkg::*;

  logic [XlenW-1:0] mask, a, b, res1;
  logic [5:0]       sh;
  logic [6:0]       rsh;
  logic             asgn;
  logic [1:0]       st1;

  // stage 1 registers
  logic             v1;
  logic [3:0]       mode1;
  logic             wide1, sgn1;
  logic [XlenW-1:0] a1, b1, r1;
  logic [1:0]       status1;
  logic [63:0]      pp0;
  logic [31:0]      pp1, pp2;

  // stage 2 logic
  logic [XlenW-1:0] sa, sb, mul;
  logic             na, nb;

  // Operand masking and shift amounts
  always_comb begin
    mask = is_64bit ? {XlenW{1'b1}} : {{HalfW{1'b0}}, {HalfW{1'b1}}};
    a    = lhs_operand & mask;
    b    = rhs_operand & mask;
    sh   = rhs_operand[5:0] & (is_64bit ? 6'h3f : 6'h1f);
    rsh  = (is_64bit ? 7'd64 : 7'd32) - {1'b0, sh};
    asgn = is_64bit ? a[63] : a[31];
  end

  // Simple operations: add, subtract, logic, shifts and rotates
  always_comb begin
    case (mode)
      OP_ADD:  res1 = a + b;
      OP_SUB:  res1 = a - b;
      OP_AND:  res1 = a & b;
      OP_OR:   res1 = a | b;
      OP_XOR:  res1 = a ^ b;
      OP_SHL:  res1 = a << sh;
      OP_SHR:  res1 = (is_signed && asgn) ? ~((~a & mask) >> sh) : (a >> sh);
      OP_ROTL: res1 = (a << sh) | (a >> rsh);
      OP_ROTR: res1 = (a >> sh) | (a << rsh);
      default: res1 = '0;
    endcase
  end

  // Division faults
  always_comb begin
    st1 = ST_OK;
    if (mode == OP_DIV || mode == OP_REM) begin
      if (b == '0) begin
        st1 = ST_DIV_ZERO;
      end else if (mode == OP_DIV && is_signed && b == mask &&
                   a == ((mask >> 1) + 64'd1)) begin
        st1 = ST_DIV_OVF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode1   <= mode;
      wide1   <= is_64bit;
      sgn1    <= is_signed;
      a1      <= a;
      b1      <= b;
      r1      <= res1;
      status1 <= st1;
      pp0     <= a[31:0] * b[31:0];
      pp1     <= 32'(a[63:32] * b[31:0]);
      pp2     <= 32'(a[31:0] * b[63:32]);
    end
  end

  // Stage 2: product sum, divider magnitudes
  always_comb begin
    mul = pp0 + {pp1 + pp2, 32'd0};
    sa  = wide1 ? a1 : {{HalfW{a1[31]}}, a1[31:0]};
    sb  = wide1 ? b1 : {{HalfW{b1[31]}}, b1[31:0]};
    na  = sgn1 & sa[63];
    nb  = sgn1 & sb[63];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl.mode   <= mode1;
      ctl.wide   <= wide1;
      ctl.status <= status1;
      ctl.neg_q  <= na ^ nb;
      ctl.neg_r  <= na;
      ctl.res    <= (mode1 == OP_MUL) ? mul : r1;
      div.rem    <= '0;
      div.quo    <= sgn1 ? (na ? (~sa + 64'd1) : sa) : a1;
      div.dvs    <= sgn1 ? (nb ? (~sb + 64'd1) : sb) : b1;
    end
  end
endmodule

// ===== sv/wialu_div_stage.sv =====
// One restoring division step: one quotient bit per stage.
module wialu_div_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  wialu_pkg::ctl_t      in_ctl,
  input  wialu_pkg::div_t      in_div,
  output logic                 valid,
  output wialu_pkg::ctl_t      ctl,
  output wialu_pkg::div_t      div
);
  import wialu_pkg::*;

  logic [XlenW:0] trial, diff;
  logic           ge;

  // Trial subtract of the divisor
  always_comb begin
    trial = {in_div.rem, in_div.quo[XlenW-1]};
    diff  = trial - {1'b0, in_div.dvs};
    ge    = ~diff[XlenW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl     <= in_ctl;
      div.rem <= ge ? diff[XlenW-1:0] : trial[XlenW-1:0];
      div.quo <= {in_div.quo[XlenW-2:0], ge};
      div.dvs <= in_div.dvs;
    end
  end
endmodule

// ===== sv/wialu_back.sv =====
// Output stage: quotient/remainder sign fix, result select and output register.
module wialu_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  wialu_pkg::ctl_t  in_ctl,
  input  wialu_pkg::div_t  in_div,
  output logic             valid,
  output logic [63:0]      result_value,
  output logic [1:0]       status
);
  import wialu_pkg::*;

  logic [XlenW-1:0] mask, qv, rv, sel;

  always_comb begin
    mask = in_ctl.wide ? {XlenW{1'b1}} : {{HalfW{1'b0}}, {HalfW{1'b1}}};
    qv   = in_ctl.neg_q ? (~in_div.quo + 64'd1) : in_div.quo;
    rv   = in_ctl.neg_r ? (~in_div.rem + 64'd1) : in_div.rem;
    if (in_ctl.status != ST_OK) begin
      sel = '0;
    end else if (in_ctl.mode == OP_DIV) begin
      sel = qv;
    end else if (in_ctl.mode == OP_REM) begin
      sel = rv;
    end else begin
      sel = in_ctl.res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_value <= sel & mask;
      status       <= in_ctl.status;
    end
  end
endmodule

// ===== sv/wasm_integer_alu_unit.sv =====
// Pipelined WebAssembly integer ALU, 32/64-bit, one operation per cycle.
// Every operation takes the same path from input transfer to result valid:
// 2 front stages, 64 restoring-divider stages, 1 output stage.
// Throughput: one item per cycle; the whole pipeline advances unless the
// output register holds a result that is not taken.
// Reset: synchronous rst clears all stage valid bits; no other state.
module wasm_integer_alu_unit (
  input logic         clk,
  input logic         rst,
  wialu_req_if.sink   req,
  wialu_rsp_if.source rsp
);
  import wialu_pkg::*;

  logic en;
  logic v   [DivSteps+1];
  ctl_t ctl [DivSteps+1];
  div_t div [DivSteps+1];

  // Global advance: stall only on a held, untaken result
  assign en        = ~rsp.valid | rsp.ready;
  assign req.ready = en;

  wialu_front u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (req.valid),
    .mode        (req.mode),
    .is_64bit    (req.is_64bit),
    .is_signed   (req.is_signed),
    .lhs_operand (req.lhs_operand),
    .rhs_operand (req.rhs_operand),
    .valid       (v[0]),
    .ctl         (ctl[0]),
    .div         (div[0])
  );

  // Divider chain
  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    wialu_div_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (v[i]),
      .in_ctl   (ctl[i]),
      .in_div   (div[i]),
      .valid    (v[i+1]),
      .ctl      (ctl[i+1]),
      .div      (div[i+1])
    );
  end

  wialu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (v[DivSteps]),
    .in_ctl       (ctl[DivSteps]),
    .in_div       (div[DivSteps]),
    .valid        (rsp.valid),
    .result_value (rsp.result_value),
    .status       (rsp.status)
  );
endmodule

// ===== verif/alu_checker.sv =====
// Checker that predicts each ALU result from request transfers and compares responses.
`timescale 1ns / 1ps
module alu_checker (
  input  logic        clk,
  input  logic        rst,
  wialu_req_if.sink   req_mon,
  wialu_rsp_if.sink   rsp_mon,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);
  import wialu_pkg::*;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
  } alu_result_t;

  alu_result_t expected_results[$];

  // Signed quotient or remainder on sign-extended 64-bit operands
  function automatic logic [63:0] signed_quot_rem(logic [63:0] a, logic [63:0] b,
                                                  bit want_rem);
    logic [63:0] ma, mb, q, r;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q = ma / mb;
    r = ma % mb;
    if (want_rem) return a[63] ? -r : r;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  function automatic alu_result_t compute_alu(logic [3:0] op, logic wide, logic sgn,
                                              logic [63:0] lhs, logic [63:0] rhs);
    alu_result_t out;
    logic [63:0] mask, signbit, a, b, sa, sb;
    int unsigned w, sh;
    mask    = wide ? '1 : 64'hFFFF_FFFF;
    signbit = wide ? 64'h8000_0000_0000_0000 : 64'h8000_0000;
    w       = wide ? 64 : 32;
    a = lhs & mask;
    b = rhs & mask;
    sh = 32'(b[5:0]) & (w - 1);
    out.value  = '0;
    out.status = ST_OK;
    case (op)
      OP_ADD: out.value = a + b;
      OP_SUB: out.value = a - b;
      OP_MUL: out.value = a * b;
      OP_DIV, OP_REM: begin
        if (b == 0) begin
          out.status = ST_DIV_ZERO;
        end else if (!sgn) begin
          out.value = (op == OP_DIV) ? a / b : a % b;
        end else if (a == signbit && b == mask) begin
          // most negative by minus one: div traps, rem is zero
          if (op == OP_DIV) out.status = ST_DIV_OVF;
        end else begin
          sa = (a & signbit) != 0 ? (a | ~mask) : a;
          sb = (b & signbit) != 0 ? (b | ~mask) : b;
          out.value = signed_quot_rem(sa, sb, op == OP_REM);
        end
      end
      OP_AND: out.value = a & b;
      OP_OR:  out.value = a | b;
      OP_XOR: out.value = a ^ b;
      OP_SHL: out.value = a << sh;
      OP_SHR: out.value = (sgn && (a & signbit) != 0) ? ~((~a & mask) >> sh) : a >> sh;
      OP_ROTL: out.value = (sh == 0) ? a : ((a << sh) | (a >> (w - sh)));
      OP_ROTR: out.value = (sh == 0) ? a : ((a >> sh) | (a << (w - sh)));
      default: out.value = '0;
    endcase
    out.value = out.value & mask;
    return out;
  endfunction

  always @(posedge clk) begin
    alu_result_t exp_res;
    if (rst) begin
      fail_count    <= 0;
      result_count  <= 0;
      pending_count <= 0;
    end else begin
      // request transfer: queue the predicted result
      if (req_mon.valid && req_mon.ready)
        expected_results.push_back(compute_alu(req_mon.mode, req_mon.is_64bit,
                                               req_mon.is_signed, req_mon.lhs_operand,
                                               req_mon.rhs_operand));
      // response transfer: compare with the oldest prediction
      if (rsp_mon.valid && rsp_mon.ready) begin
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          $error("unexpected result: result_value=%h status=%0d",
                 rsp_mon.result_value, rsp_mon.status);
          fail_count <= fail_count + 1;
        end else begin
          exp_res = expected_results.pop_front();
          if (rsp_mon.result_value !== exp_res.value || rsp_mon.status !== exp_res.status)
            fail_count <= fail_count + 1;
          if (rsp_mon.result_value !== exp_res.value)
            $error("result_value mismatch: expected %h actual %h",
                   exp_res.value, rsp_mon.result_value);
          if (rsp_mon.status !== exp_res.status)
            $error("status mismatch: expected %0d actual %0d",
                   exp_res.status, rsp_mon.status);
        end
      end
      pending_count <= expected_results.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the ALU testbench: clock, reset, request stimulus, response stalls, verdict.
`timescale 1ns / 1ps
module testbench;
  import wialu_pkg::*;

  localparam int NumRandom  = 1330;
  localparam int CycleLimit = 200000;
  localparam int DrainWait  = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycle_count = 0;
  int   fail_count, pending_count, result_count;
  int   sent_count = 0;
  bit   hold_off = 1'b0;

  wialu_req_if req_ch();
  wialu_rsp_if rsp_ch();

  always #2 clk = ~clk;

  wasm_integer_alu_unit u_dut (.clk(clk), .rst(rst), .req(req_ch.sink), .rsp(rsp_ch.source));

  alu_checker u_checker (
    .clk(clk), .rst(rst), .req_mon(req_ch.sink), .rsp_mon(rsp_ch.sink),
    .fail_count(fail_count), .pending_count(pending_count), .result_count(result_count)
  );

  initial begin
    req_ch.valid = 1'b0;
    req_ch.mode = OP_ADD;
    req_ch.is_64bit = 1'b0;
    req_ch.is_signed = 1'b0;
    req_ch.lhs_operand = '0;
    req_ch.rhs_operand = '0;
    rsp_ch.ready = 1'b0;
  end

  // Operand with a bias toward corner values
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h0000_0000_8000_0000;
      4: return 64'h0000_0000_FFFF_FFFF;
      5: return 64'($urandom_range(0, 70));
      6: return {32'($urandom), 32'($urandom_range(0, 3)) - 32'd1};
      default: return {32'($urandom), 32'($urandom)};
    endcase
  endfunction

  // Offer one request after a random gap and hold it until transfer
  task automatic send_op(logic [3:0] op, logic wide, logic sgn,
                         logic [63:0] lhs, logic [63:0] rhs);
    int gap;
    gap = $urandom_range(0, 3);
    if (sent_count % 300 < 40) gap = 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.mode        <= op;
    req_ch.is_64bit    <= wide;
    req_ch.is_signed   <= sgn;
    req_ch.lhs_operand <= lhs;
    req_ch.rhs_operand <= rhs;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent_count++;
  endtask

  // Response side: random stalls, plus one long hold-off that backs up the pipeline
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        rsp_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      stall = (result_count % 400 < 50) ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic [3:0] op;
    logic       wide;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: every operation once, at alternating widths and signedness, plus the trap and corner cases
    for (int k = 0; k <= 11; k++) send_op(4'(k), k[0], k[1], 64'hFFFF_FFFF_8000_0001,
                                          64'h0000_0000_0000_0025);
    send_op(OP_DIV, 1'b0, 1'b0, 64'h1234, 64'h0);
    send_op(OP_REM, 1'b1, 1'b1, 64'h1234, 64'h0);
    send_op(OP_DIV, 1'b1, 1'b1, 64'h8000_0000_0000_0000, '1);
    send_op(OP_DIV, 1'b0, 1'b1, 64'hABCD_0000_8000_0000, 64'h1111_1111_FFFF_FFFF);
    send_op(OP_REM, 1'b1, 1'b1, 64'h8000_0000_0000_0000, '1);
    send_op(OP_REM, 1'b0, 1'b1, 64'h8000_0000, 64'hFFFF_FFFF);
    send_op(OP_SHR, 1'b1, 1'b1, '1, 64'd63);
    send_op(OP_ROTR, 1'b0, 1'b0, 64'h0000_0001_0000_0001, 64'd32);
    send_op(4'd12, 1'b1, 1'b0, '1, '1);
    send_op(4'd15, 1'b0, 1'b1, '1, '1);
    send_op(OP_MUL, 1'b1, 1'b0, '1, '1);
    send_op(OP_ADD, 1'b1, 1'b1, '1, 64'd1);

    // Random: mostly valid operations, a few unused codes
    for (int n = 0; n < NumRandom; n++) begin
      if (n == 400) hold_off = 1'b1;
      op   = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                          : 4'($urandom_range(0, 11));
      wide = 1'($urandom_range(0, 1));
      send_op(op, wide, 1'($urandom), pick_operand(), pick_operand());
    end
    req_ch.valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    $display("Covered %0d requests over all twelve operations at both widths,", sent_count);
    $display("including divide traps, unused codes and a long response stall.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/wialu_pkg.sv
sv/wialu_if.sv
sv/wialu_front.sv
sv/wialu_div_stage.sv
sv/wialu_back.sv
sv/wasm_integer_alu_unit.sv
verif/alu_checker.sv
verif/testbench.sv
